// ===== rtl/tdsch_pkg.sv =====
// Shared types and constants for the two-task delay scheduler.
// No dependencies; used by tdsch_core and two_task_delay_scheduler.
`default_nettype none

package tdsch_pkg;

  // Default delay counter width.
  localparam int unsigned DelayBitsDef = 32;

  // Field widths fixed by the interface.
  localparam int unsigned AmountW = 32;
  localparam int unsigned LockW   = 8;

  // Lock may increment only while at or below this value (saturates at 255).
  localparam logic [LockW-1:0] LockMax = 8'd254;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DELAY  = 2'd1,
    OP_LOCK   = 2'd2,
    OP_UNLOCK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TASK_FIRST  = 2'd0,
    TASK_SECOND = 2'd1,
    TASK_IDLE   = 2'd2
  } task_e;

  // One result beat as produced by the core.
  typedef struct packed {
    logic             switched;
    task_e            run_task;
    logic [LockW-1:0] lock_depth;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/two_task_delay_scheduler.sv =====
// Top level of the two-task delay scheduler: input register, result
// register and handshake. Depends on tdsch_pkg and tdsch_core.
`default_nettype none

// Two-task delay scheduler. Each input beat carries one operation (tick,
// delay the running task, lock, unlock) and yields exactly one result beat
// with the switch flag, the task now running (0 first, 1 second, 2 idle) and
// the lock depth. A beat is registered on entry and processed by the core
// against the scheduler state once the output register can take its result;
// one beat per cycle is sustained while the output is not stalled.
// The input keeps flowing while a result waits, as long as the single input
// register can drain; stall on the input rises only when both the input
// register and the output register are full and the output is stalled.
module two_task_delay_scheduler #(
  parameter int unsigned DELAY_BITS = tdsch_pkg::DelayBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic [tdsch_pkg::AmountW-1:0]  delay_amount_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                switched_o,
  output logic [1:0]                          running_task_o,
  output logic [tdsch_pkg::LockW-1:0]         lock_depth_o
);

  // Input register
  logic                              in_vld_q;
  tdsch_pkg::op_e                    op_q;
  logic [tdsch_pkg::AmountW-1:0]     amount_q;

  // Result register
  logic                              out_vld_q;
  tdsch_pkg::res_t                   res_q;

  tdsch_pkg::res_t                   core_res;
  logic                              out_free;
  logic                              fire;
  logic                              in_take;

  // Output register can take a new beat when empty or being drained.
  assign out_free   = !out_vld_q || !out_stall_i;
  // Core processes the held beat and commits state when the result fits.
  assign fire       = in_vld_q && out_free;
  // Input register free when empty or moving on this cycle.
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= tdsch_pkg::op_e'(opcode_i);
      amount_q <= delay_amount_i;
    end
  end

  tdsch_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .op_i     (op_q),
    .amount_i (amount_q),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign switched_o     = res_q.switched;
  assign running_task_o = res_q.run_task;
  assign lock_depth_o   = res_q.lock_depth;

endmodule

`default_nettype wire

// ===== rtl/tdsch_core.sv =====
// Scheduler state (delay counters, current task, lock count) and the
// combinational update for one operation. Depends on tdsch_pkg.
`default_nettype none

module tdsch_core #(
  parameter int unsigned DELAY_BITS = tdsch_pkg::DelayBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fire_i,
  input  wire tdsch_pkg::op_e                 op_i,
  input  wire logic [tdsch_pkg::AmountW-1:0]  amount_i,
  output tdsch_pkg::res_t                     res_o
);

  logic [DELAY_BITS-1:0]       first_q, first_d;
  logic [DELAY_BITS-1:0]       second_q, second_d;
  tdsch_pkg::task_e            cur_q, cur_d;
  logic [tdsch_pkg::LockW-1:0] lock_q, lock_d;
  logic [DELAY_BITS-1:0]       amount;
  logic                        do_sched;
  logic                        sw;

  // Amount is kept to the counter width (zero-extended when wider).
  assign amount = DELAY_BITS'(amount_i);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    lock_d   = lock_q;
    cur_d    = cur_q;
    do_sched = 1'b0;
    sw       = 1'b0;

    unique case (op_i)
      tdsch_pkg::OP_TICK: begin
        if (first_q != '0) first_d = first_q - 1'b1;
        if (second_q != '0) second_d = second_q - 1'b1;
        do_sched = 1'b1;
      end
      tdsch_pkg::OP_DELAY: begin
        if (cur_q == tdsch_pkg::TASK_FIRST) begin
          first_d = amount;
        end else if (cur_q != tdsch_pkg::TASK_IDLE) begin
          second_d = amount;
        end
        do_sched = 1'b1;
      end
      tdsch_pkg::OP_LOCK: begin
        if (lock_q <= tdsch_pkg::LockMax) lock_d = lock_q + 1'b1;
      end
      default: begin
        if (lock_q != '0) lock_d = lock_q - 1'b1;
        do_sched = (lock_d == '0);
      end
    endcase

    // Preference rules work on the freshly updated counters.
    if (do_sched && lock_d == '0) begin
      unique case (cur_q)
        tdsch_pkg::TASK_IDLE: begin
          if (first_d == '0) begin
            cur_d = tdsch_pkg::TASK_FIRST;
            sw    = 1'b1;
          end else if (second_d == '0) begin
            cur_d = tdsch_pkg::TASK_SECOND;
            sw    = 1'b1;
          end
        end
        tdsch_pkg::TASK_FIRST: begin
          if (second_d == '0) begin
            cur_d = tdsch_pkg::TASK_SECOND;
            sw    = 1'b1;
          end else if (first_d != '0) begin
            cur_d = tdsch_pkg::TASK_IDLE;
            sw    = 1'b1;
          end
        end
        default: begin
          // second task (an unused code behaves the same)
          if (first_d == '0) begin
            cur_d = tdsch_pkg::TASK_FIRST;
            sw    = 1'b1;
          end else if (second_d != '0) begin
            cur_d = tdsch_pkg::TASK_IDLE;
            sw    = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      cur_q    <= tdsch_pkg::TASK_FIRST;
      lock_q   <= '0;
    end else if (fire_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      cur_q    <= cur_d;
      lock_q   <= lock_d;
    end
  end

  assign res_o.switched   = sw;
  assign res_o.run_task   = cur_d;
  assign res_o.lock_depth = lock_d;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for two_task_delay_scheduler.
// Needs tdsch_pkg and the scheduler RTL; reads nothing at run time.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DelayW = tdsch_pkg::DelayBitsDef;
  localparam int unsigned HoldCycles = 50;

  // One input beat as queued for the driver.
  typedef struct packed {
    tdsch_pkg::op_e                op;
    logic [tdsch_pkg::AmountW-1:0] amount;
  } op_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    opcode_i = tdsch_pkg::OP_TICK;
  logic [tdsch_pkg::AmountW-1:0] delay_amount_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          switched_o;
  logic [1:0]                    running_task_o;
  logic [tdsch_pkg::LockW-1:0]   lock_depth_o;

  two_task_delay_scheduler #(
    .DELAY_BITS(DelayW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .delay_amount_i (delay_amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .switched_o     (switched_o),
    .running_task_o (running_task_o),
    .lock_depth_o   (lock_depth_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ------------------------------------------------------------------
  // Scheduler state as the testbench tracks it
  // ------------------------------------------------------------------
  logic [DelayW-1:0]           first_dly;
  logic [DelayW-1:0]           second_dly;
  tdsch_pkg::task_e            cur_task;
  logic [tdsch_pkg::LockW-1:0] lock_cnt;

  op_beat_t        ops_todo[$];     // beats not yet offered
  tdsch_pkg::res_t results_due[$];  // results owed by the block, oldest first

  int send_idle_pct = 0;     // chance per cycle that the sender idles
  int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
  bit hold_req = 1'b0;       // asks the receiver for one long hold-off
  int hold_left = 0;
  bit took_beat = 1'b0;      // input beat accepted at the last rising edge
  int err_cnt = 0;

  int n_op[4];
  int n_switch = 0;
  int n_idle = 0;
  int peak_lock = 0;

  // Picks the next task by the fixed preference rules. Nothing moves while
  // the lock is held. Every rule that fires lands on a task other than the
  // current one, so a change of task is the switch flag.
  task automatic pick_task(output logic sw);
    tdsch_pkg::task_e nxt;
    nxt = cur_task;
    if (lock_cnt == '0) begin
      case (cur_task)
        tdsch_pkg::TASK_IDLE: begin
          if (first_dly == '0) nxt = tdsch_pkg::TASK_FIRST;
          else if (second_dly == '0) nxt = tdsch_pkg::TASK_SECOND;
        end
        tdsch_pkg::TASK_FIRST: begin
          if (second_dly == '0) nxt = tdsch_pkg::TASK_SECOND;
          else if (first_dly != '0) nxt = tdsch_pkg::TASK_IDLE;
        end
        // an out-of-range task code behaves as the second task
        default: begin
          if (first_dly == '0) nxt = tdsch_pkg::TASK_FIRST;
          else if (second_dly != '0) nxt = tdsch_pkg::TASK_IDLE;
        end
      endcase
    end
    sw = (nxt != cur_task);
    cur_task = nxt;
  endtask

  // Applies one operation to the tracked state and returns the result beat
  // the block must produce for it.
  task automatic apply_op(input tdsch_pkg::op_e op,
                          input logic [tdsch_pkg::AmountW-1:0] amt,
                          output tdsch_pkg::res_t r);
    logic sw;
    sw = 1'b0;
    case (op)
      tdsch_pkg::OP_TICK: begin
        if (first_dly != '0) first_dly = first_dly - 1'b1;
        if (second_dly != '0) second_dly = second_dly - 1'b1;
        pick_task(sw);
      end
      tdsch_pkg::OP_DELAY: begin
        // the idle task has no counter: only the rescheduling takes effect
        if (cur_task == tdsch_pkg::TASK_FIRST) first_dly = DelayW'(amt);
        else if (cur_task != tdsch_pkg::TASK_IDLE) second_dly = DelayW'(amt);
        pick_task(sw);
      end
      tdsch_pkg::OP_LOCK: begin
        // sticks at 255
        if (lock_cnt <= tdsch_pkg::LockMax) lock_cnt = lock_cnt + 1'b1;
      end
      default: begin
        // unlock at zero stays at zero and still reschedules
        if (lock_cnt != '0) lock_cnt = lock_cnt - 1'b1;
        if (lock_cnt == '0) pick_task(sw);
      end
    endcase
    r.switched   = sw;
    r.run_task   = cur_task;
    r.lock_depth = lock_cnt;
  endtask

  // ------------------------------------------------------------------
  // Input side: acceptance at the rising edge, driving at the falling edge
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : take_in
    tdsch_pkg::res_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      took_beat = 1'b1;
      apply_op(tdsch_pkg::op_e'(opcode_i), delay_amount_i, r);
      results_due.push_back(r);
      n_op[opcode_i]++;
      if (r.switched) n_switch++;
      if (r.switched && r.run_task == tdsch_pkg::TASK_IDLE) n_idle++;
      if (int'(r.lock_depth) > peak_lock) peak_lock = int'(r.lock_depth);
    end
  end

  // A beat on offer stays put until taken; between beats the sender may idle.
  always @(negedge clk_i) begin : drive_in
    op_beat_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !took_beat) begin
      // stalled: hold valid and payload
    end else if (ops_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      b = ops_todo.pop_front();
      in_valid_i     <= 1'b1;
      opcode_i       <= b.op;
      delay_amount_i <= b.amount;
    end else begin
      in_valid_i <= 1'b0;
    end
    took_beat = 1'b0;
  end

  // ------------------------------------------------------------------
  // Result side: random stall plus the one long hold-off
  // ------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_stall
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_out
    tdsch_pkg::res_t e;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected (switched %b task %0d lock %0d)",
                 $time, switched_o, running_task_o, lock_depth_o);
        err_cnt++;
      end else begin
        e = results_due.pop_front();
        if (switched_o !== e.switched) begin
          $display("%0t: switched expected %b got %b", $time, e.switched, switched_o);
          err_cnt++;
        end
        if (running_task_o !== e.run_task) begin
          $display("%0t: running_task expected %0d got %0d",
                   $time, e.run_task, running_task_o);
          err_cnt++;
        end
        if (lock_depth_o !== e.lock_depth) begin
          $display("%0t: lock_depth expected %0d got %0d", $time, e.lock_depth, lock_depth_o);
          err_cnt++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  task automatic add_op(input tdsch_pkg::op_e op,
                        input logic [tdsch_pkg::AmountW-1:0] amt);
    op_beat_t b;
    b.op     = op;
    b.amount = amt;
    ops_todo.push_back(b);
  endtask

  // Mostly short delays so counters run out and tasks keep trading places.
  function automatic logic [tdsch_pkg::AmountW-1:0] short_amount();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4);
    else if (r < 95) return $urandom_range(20, 5);
    else return $urandom_range(300, 21);
  endfunction

  // Random traffic: tick runs, delays, lock brackets around ticks and delays,
  // and a little noise in the form of stray locks and unlocks.
  task automatic gen_random(input int n_items);
    int cnt;
    int r;
    int k;
    int depth;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        k = $urandom_range(4, 1);
        repeat (k) add_op(tdsch_pkg::OP_TICK, $urandom);
        cnt += k;
      end else if (r < 75) begin
        add_op(tdsch_pkg::OP_DELAY, short_amount());
        cnt++;
      end else if (r < 92) begin
        depth = $urandom_range(3, 1);
        k = $urandom_range(5, 1);
        repeat (depth) add_op(tdsch_pkg::OP_LOCK, $urandom);
        repeat (k) begin
          if ($urandom_range(1)) add_op(tdsch_pkg::OP_TICK, $urandom);
          else add_op(tdsch_pkg::OP_DELAY, short_amount());
        end
        repeat (depth) add_op(tdsch_pkg::OP_UNLOCK, $urandom);
        cnt += 2 * depth + k;
      end else begin
        if ($urandom_range(1)) add_op(tdsch_pkg::OP_LOCK, $urandom);
        else add_op(tdsch_pkg::OP_UNLOCK, $urandom);
        cnt++;
      end
    end
  endtask

  // Sender pause: wait until every queued beat went in and came back out.
  // Checked just after the rising edge so the edge's own updates are done.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (ops_todo.size() != 0 || in_valid_i || results_due.size() != 0);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin : stimulus
    int send_pct[4] = '{0, 48, 0, 6};
    int recv_pct[4] = '{0, 0, 48, 6};

    first_dly  = '0;
    second_dly = '0;
    cur_task   = tdsch_pkg::TASK_FIRST;
    lock_cnt   = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk through the scheduling rules, no idling.
    add_op(tdsch_pkg::OP_UNLOCK, 32'h0);          // unlock at zero still reschedules
    add_op(tdsch_pkg::OP_TICK,   32'h0);          // second back to first
    add_op(tdsch_pkg::OP_DELAY,  32'd2);          // first sleeps, second runs
    add_op(tdsch_pkg::OP_DELAY,  32'd3);          // both asleep: idle
    add_op(tdsch_pkg::OP_DELAY,  32'hFFFF_FFFF);  // delay while idle, amount unused
    add_op(tdsch_pkg::OP_DELAY,  32'hAAAA_5555);
    add_op(tdsch_pkg::OP_DELAY,  32'h5555_AAAA);
    add_op(tdsch_pkg::OP_TICK,   32'hFFFF_FFFF);  // nobody ready yet
    add_op(tdsch_pkg::OP_TICK,   32'h0);          // first wakes
    add_op(tdsch_pkg::OP_LOCK,   32'h0);
    add_op(tdsch_pkg::OP_LOCK,   32'h0);
    add_op(tdsch_pkg::OP_TICK,   32'h0);          // second ready but locked
    add_op(tdsch_pkg::OP_DELAY,  32'd4);          // counter set, no switch under lock
    add_op(tdsch_pkg::OP_UNLOCK, 32'h0);          // still locked
    add_op(tdsch_pkg::OP_UNLOCK, 32'h0);          // released: second runs
    add_op(tdsch_pkg::OP_DELAY,  32'd0);          // second stays, first still asleep
    add_op(tdsch_pkg::OP_DELAY,  32'd1);          // second sleeps: idle
    add_op(tdsch_pkg::OP_TICK,   32'h0);          // second wakes from idle
    add_op(tdsch_pkg::OP_DELAY,  32'd0);
    add_op(tdsch_pkg::OP_TICK,   32'h0);
    add_op(tdsch_pkg::OP_TICK,   32'h0);
    add_op(tdsch_pkg::OP_TICK,   32'h0);          // first wakes, second yields
    add_op(tdsch_pkg::OP_DELAY,  32'd0);          // first sleeps no time, yields to ready second
    wait_drained();

    // Random traffic in four idling phases. The first, with no idling, also
    // carries the long receiver hold-off so the block backs up its input.
    for (int p = 0; p < 4; p++) begin
      set_idling(send_pct[p], recv_pct[p]);
      gen_random(36);
      if (p == 0) hold_req = 1'b1;
      wait_drained();
    end

    // Full-width delays, since they park a task for good.
    set_idling(6, 6);
    repeat (8) begin
      add_op(tdsch_pkg::OP_DELAY, $urandom);
      add_op(tdsch_pkg::OP_TICK, $urandom);
    end
    wait_drained();

    // Lock saturation last: more locks than 255 so the depth saturates, act
    // while locked, back off a little. The lock stays held to the end of the run.
    repeat (260) add_op(tdsch_pkg::OP_LOCK, $urandom);
    add_op(tdsch_pkg::OP_TICK, $urandom);
    add_op(tdsch_pkg::OP_DELAY, short_amount());
    repeat (4) add_op(tdsch_pkg::OP_UNLOCK, $urandom);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      err_cnt++;
    end
    $display("Ran %0d beats: %0d ticks, %0d delays, %0d locks, %0d unlocks.",
             n_op[tdsch_pkg::OP_TICK] + n_op[tdsch_pkg::OP_DELAY] +
             n_op[tdsch_pkg::OP_LOCK] + n_op[tdsch_pkg::OP_UNLOCK],
             n_op[tdsch_pkg::OP_TICK], n_op[tdsch_pkg::OP_DELAY],
             n_op[tdsch_pkg::OP_LOCK], n_op[tdsch_pkg::OP_UNLOCK]);
    $display("Saw %0d task switches (%0d into idle), lock depth up to %0d.",
             n_switch, n_idle, peak_lock);
    if (err_cnt == 0) begin
      $display("PASS two_task_delay_scheduler");
    end else begin
      $display("FAIL two_task_delay_scheduler");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
    $display("FAIL two_task_delay_scheduler");
    $finish;
  end

endmodule
